@@ hdl/sktsi_pkg.sv @@
// ============================================================================
// sktsi_pkg
// Shared constants, codes and controller/datapath interface types for the
// sorted key table with search and insert.
// ============================================================================
`default_nettype none

package sktsi_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BITS    = 64;
    localparam int VALUE_BITS  = 32;

    localparam int ADDR_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int CAP_W    = 7;
    localparam int POS_W    = 7;
    localparam int TOTAL_W  = 7;
    localparam int STATUS_W = 3;
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int ROW_W    = KEY_BITS + VALUE_BITS;

    localparam int S_DATA_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int M_FIELD_W = VALUE_BITS + POS_W + TOTAL_W;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_ADDED     = 3'd2,
        ST_UPDATED   = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_DECIDE,
        S_SHIFT,
        S_PLACE,
        S_UPDATE,
        S_RESPOND
    } state_t;

    typedef struct packed {
        logic    load;
        logic    search_rd;
        logic    search_cmp;
        logic    shift_init;
        logic    shift_rd;
        logic    place;
        logic    update;
        logic    result_load;
        status_t result_status;
    } cmd_t;

    typedef struct packed {
        logic search_done;
        logic hit;
        logic full;
        logic shift_done;
        op_t  op;
    } stat_t;

endpackage

`default_nettype wire

@@ hdl/sktsi_dpath.sv @@
// ============================================================================
// sktsi_dpath
// Table memory, request registers, binary search bounds, shift pointer,
// entry count, capacity register and the result register.
// ============================================================================
`default_nettype none

module sktsi_dpath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire sktsi_pkg::cmd_t                  cmd,
    output sktsi_pkg::stat_t                      stat,
    input  wire logic [sktsi_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                             s_tuser,
    input  wire logic                             cfg_valid,
    input  wire logic [sktsi_pkg::CAP_W-1:0]      cfg_data,
    output logic      [sktsi_pkg::M_DATA_W-1:0]   m_tdata,
    output logic      [sktsi_pkg::STATUS_W-1:0]   m_tuser
);

    // Table rows hold the key in the upper bits and the value in the lower bits.
    logic [sktsi_pkg::ROW_W-1:0]      mem [sktsi_pkg::TABLE_DEPTH];
    logic [sktsi_pkg::ROW_W-1:0]      rd_data_reg;
    logic                             mem_we;
    logic                             mem_re;
    logic [sktsi_pkg::ADDR_W-1:0]     mem_wa;
    logic [sktsi_pkg::ADDR_W-1:0]     mem_ra;
    logic [sktsi_pkg::ROW_W-1:0]      mem_wd;

    sktsi_pkg::op_t                   op_reg;
    logic [sktsi_pkg::KEY_BITS-1:0]   key_reg;
    logic [sktsi_pkg::VALUE_BITS-1:0] val_reg;
    logic [sktsi_pkg::CNT_W-1:0]      lo_reg, lo_next;
    logic [sktsi_pkg::CNT_W-1:0]      hi_reg, hi_next;
    logic [sktsi_pkg::ADDR_W-1:0]     mid_reg;
    logic [sktsi_pkg::CNT_W-1:0]      mid_full;
    logic                             hit_reg, hit_next;
    logic [sktsi_pkg::VALUE_BITS-1:0] hit_val_reg, hit_val_next;
    logic [sktsi_pkg::CNT_W-1:0]      sp_reg, sp_next;
    logic                             pend_reg;
    logic [sktsi_pkg::ADDR_W-1:0]     wa_reg;
    logic [sktsi_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [sktsi_pkg::CAP_W-1:0]      cap_reg;
    logic [sktsi_pkg::CMP_W-1:0]      cap_eff;

    logic [sktsi_pkg::KEY_BITS-1:0]   rd_key;
    logic [sktsi_pkg::VALUE_BITS-1:0] rd_val;
    logic [sktsi_pkg::POS_W-1:0]      lb_pos;

    logic [sktsi_pkg::VALUE_BITS-1:0] found_value_reg;
    logic [sktsi_pkg::POS_W-1:0]      position_reg;
    logic [sktsi_pkg::TOTAL_W-1:0]    entry_total_reg;
    logic [sktsi_pkg::STATUS_W-1:0]   status_reg;

    assign rd_key   = rd_data_reg[sktsi_pkg::ROW_W-1 -: sktsi_pkg::KEY_BITS];
    assign rd_val   = rd_data_reg[sktsi_pkg::VALUE_BITS-1:0];
    assign mid_full = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lb_pos   = sktsi_pkg::POS_W'(lo_reg);

    // A capacity above the table depth is clamped to the depth.
    assign cap_eff = (sktsi_pkg::CMP_W'(cap_reg) > sktsi_pkg::CMP_W'(sktsi_pkg::TABLE_DEPTH))
                   ? sktsi_pkg::CMP_W'(sktsi_pkg::TABLE_DEPTH)
                   : sktsi_pkg::CMP_W'(cap_reg);

    always_comb begin
        stat.search_done = (lo_reg == hi_reg);
        stat.hit         = hit_reg;
        stat.full        = (sktsi_pkg::CMP_W'(count_reg) >= cap_eff);
        stat.shift_done  = (sp_reg == lo_reg);
        stat.op          = op_reg;
    end

    // Memory port selection. A pending shift write and a placement never
    // fall in the same cycle.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = wa_reg;
        mem_wd = rd_data_reg;
        if (pend_reg) begin
            mem_we = 1'b1;
        end else if (cmd.place || cmd.update) begin
            mem_we = 1'b1;
            mem_wa = lo_reg[sktsi_pkg::ADDR_W-1:0];
            mem_wd = {key_reg, val_reg};
        end
        mem_re = cmd.search_rd || cmd.shift_rd;
        if (cmd.shift_rd) begin
            mem_ra = sktsi_pkg::ADDR_W'(sp_reg - sktsi_pkg::CNT_W'(1));
        end else begin
            mem_ra = mid_full[sktsi_pkg::ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_comb begin
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        hit_next     = hit_reg;
        hit_val_next = hit_val_reg;
        sp_next      = sp_reg;
        count_next   = count_reg;
        if (cmd.load) begin
            lo_next  = '0;
            hi_next  = count_reg;
            hit_next = 1'b0;
        end
        // The lower bound ends at the last slot that moved hi, so the match
        // flag of that step tells whether the key is present.
        if (cmd.search_cmp) begin
            if (rd_key < key_reg) begin
                lo_next = sktsi_pkg::CNT_W'(mid_reg) + sktsi_pkg::CNT_W'(1);
            end else begin
                hi_next      = sktsi_pkg::CNT_W'(mid_reg);
                hit_next     = (rd_key == key_reg);
                hit_val_next = rd_val;
            end
        end
        if (cmd.shift_init) begin
            sp_next = count_reg;
        end
        if (cmd.shift_rd) begin
            sp_next = sp_reg - sktsi_pkg::CNT_W'(1);
        end
        if (cmd.place) begin
            count_next = count_reg + sktsi_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            cap_reg   <= sktsi_pkg::CAP_RESET;
            pend_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            pend_reg  <= cmd.shift_rd;
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        hit_reg     <= hit_next;
        hit_val_reg <= hit_val_next;
        sp_reg      <= sp_next;
        if (cmd.load) begin
            op_reg  <= sktsi_pkg::op_t'(s_tuser);
            key_reg <= s_tdata[sktsi_pkg::KEY_BITS-1:0];
            val_reg <= s_tdata[sktsi_pkg::KEY_BITS +: sktsi_pkg::VALUE_BITS];
        end
        if (cmd.search_rd) begin
            mid_reg <= mid_full[sktsi_pkg::ADDR_W-1:0];
        end
        if (cmd.shift_rd) begin
            wa_reg <= sp_reg[sktsi_pkg::ADDR_W-1:0];
        end
        if (cmd.result_load) begin
            status_reg      <= cmd.result_status;
            entry_total_reg <= sktsi_pkg::TOTAL_W'(count_reg);
            if (cmd.result_status == sktsi_pkg::ST_FOUND) begin
                found_value_reg <= hit_val_reg;
            end else begin
                found_value_reg <= '0;
            end
            // A miss reports the left neighbor, which is all ones when none exists.
            if (cmd.result_status == sktsi_pkg::ST_NOT_FOUND ||
                cmd.result_status == sktsi_pkg::ST_FULL) begin
                position_reg <= lb_pos - sktsi_pkg::POS_W'(1);
            end else begin
                position_reg <= lb_pos;
            end
        end
    end

    assign m_tdata = sktsi_pkg::M_DATA_W'({entry_total_reg, position_reg, found_value_reg});
    assign m_tuser = status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= sktsi_pkg::CNT_W'(sktsi_pkg::TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_place_increments: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.place |=> count_reg == $past(count_reg) + sktsi_pkg::CNT_W'(1))
        else $error("placement did not add exactly one entry");

    a_search_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.search_rd |-> lo_reg < hi_reg && hi_reg <= count_reg)
        else $error("search window is empty or beyond the entry count");

    a_shift_no_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !cmd.place && !cmd.update)
        else $error("shift write collides with placement or update");

endmodule

`default_nettype wire

@@ hdl/sktsi_ctrl.sv @@
// ============================================================================
// sktsi_ctrl
// Request sequencer: binary search steps, insert decision, shift pass,
// placement and result handoff to the output register.
// ============================================================================
`default_nettype none

module sktsi_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire sktsi_pkg::stat_t  stat,
    output sktsi_pkg::cmd_t        cmd
);

    sktsi_pkg::state_t  state_reg, state_next;
    sktsi_pkg::status_t status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        case (state_reg)
            sktsi_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = sktsi_pkg::S_SEARCH_RD;
                end
            end
            sktsi_pkg::S_SEARCH_RD: begin
                if (stat.search_done) begin
                    state_next = sktsi_pkg::S_DECIDE;
                end else begin
                    state_next = sktsi_pkg::S_SEARCH_CMP;
                end
            end
            sktsi_pkg::S_SEARCH_CMP: begin
                state_next = sktsi_pkg::S_SEARCH_RD;
            end
            sktsi_pkg::S_DECIDE: begin
                if (stat.op == sktsi_pkg::OP_LOOKUP) begin
                    status_next = stat.hit ? sktsi_pkg::ST_FOUND : sktsi_pkg::ST_NOT_FOUND;
                    state_next  = sktsi_pkg::S_RESPOND;
                end else if (stat.hit) begin
                    status_next = sktsi_pkg::ST_UPDATED;
                    state_next  = sktsi_pkg::S_UPDATE;
                end else if (stat.full) begin
                    status_next = sktsi_pkg::ST_FULL;
                    state_next  = sktsi_pkg::S_RESPOND;
                end else begin
                    status_next = sktsi_pkg::ST_ADDED;
                    state_next  = sktsi_pkg::S_SHIFT;
                end
            end
            sktsi_pkg::S_SHIFT: begin
                if (stat.shift_done) begin
                    state_next = sktsi_pkg::S_PLACE;
                end
            end
            sktsi_pkg::S_PLACE: begin
                state_next = sktsi_pkg::S_RESPOND;
            end
            sktsi_pkg::S_UPDATE: begin
                state_next = sktsi_pkg::S_RESPOND;
            end
            sktsi_pkg::S_RESPOND: begin
                if (out_free) begin
                    state_next = sktsi_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = sktsi_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd               = '0;
        cmd.result_status = status_reg;
        s_tready          = 1'b0;
        case (state_reg)
            sktsi_pkg::S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            sktsi_pkg::S_SEARCH_RD: begin
                cmd.search_rd = !stat.search_done;
            end
            sktsi_pkg::S_SEARCH_CMP: begin
                cmd.search_cmp = 1'b1;
            end
            sktsi_pkg::S_DECIDE: begin
                cmd.shift_init = (stat.op == sktsi_pkg::OP_INSERT) && !stat.hit && !stat.full;
            end
            sktsi_pkg::S_SHIFT: begin
                cmd.shift_rd = !stat.shift_done;
            end
            sktsi_pkg::S_PLACE: begin
                cmd.place = 1'b1;
            end
            sktsi_pkg::S_UPDATE: begin
                cmd.update = 1'b1;
            end
            sktsi_pkg::S_RESPOND: begin
                cmd.result_load = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.result_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sktsi_pkg::S_IDLE;
            status_reg    <= sktsi_pkg::ST_NOT_FOUND;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_accept_starts_search: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == sktsi_pkg::S_SEARCH_RD)
        else $error("accepted request did not start a search");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result_load |=> m_tvalid)
        else $error("loaded result is not presented");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result_load && out_valid_reg |-> m_tready)
        else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

@@ hdl/sorted_key_table_search_insert.sv @@
// ============================================================================
// sorted_key_table_search_insert
// Sorted key/value table with lookup and insert-or-update requests.
// ============================================================================
// The table keeps up to 64 key/value pairs in ascending key order in a
// single-port-write, registered-read memory, so every request walks the
// memory one access at a time. A request first runs a binary search in
// which each halving step passes through a read state and a compare
// state, followed by the final bound check, the decision and the result
// handoff to the output register; an update adds a write step before the
// handoff. An insert of a new key also moves every higher entry up one
// slot at one entry per cycle through the memory port before the new
// entry is placed. One request is in work at a time; the next request is
// accepted in the cycle after the previous result enters the output
// register, even if that result has not been taken yet. The capacity
// register is written through the cfg channel, which is always ready, and
// must only be written while no request is outstanding. The table needs no
// clearing pass after reset: slots at or above the entry count are never
// read.
// ============================================================================
`default_nettype none

module sorted_key_table_search_insert (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Request channel.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata from bit 0 up: key (64), value (32).
    input  wire logic [sktsi_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: op (1), 0 lookup, 1 insert or update.
    input  wire logic                             s_tuser,
    // Result channel.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata from bit 0 up: found_value (32), position (7, signed),
    // entry_total (7), zero fill.
    output logic      [sktsi_pkg::M_DATA_W-1:0]   m_tdata,
    // m_tuser: status (3).
    output logic      [sktsi_pkg::STATUS_W-1:0]   m_tuser,
    // Capacity register write.
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sktsi_pkg::CAP_W-1:0]      cfg_data
);

    sktsi_pkg::cmd_t  cmd;
    sktsi_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    sktsi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sktsi_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
